/* hdl/dts_pkg.sv */
// Shared types, constants and lookup tables of the diatonic tone sequencer.
package dts_pkg;

   // Field widths of the items.
   localparam int NOTE_W     = 3;
   localparam int KEYS_W     = 7;
   localparam int PWM_W      = 10;
   localparam int DEB_W      = 4;
   localparam int BLINK_W    = 10;
   localparam int IDX_W      = 5;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // Scale and sample table shape.
   localparam int SAMPLES_PER_PERIOD = 20;
   localparam int NOTE_COUNT         = 7;
   localparam int TABLE_SAMPLES      = 20;
   localparam int BLINK_ENTRIES      = 15;

   // Codes and reset values.
   localparam logic [NOTE_W-1:0]  NO_NOTE        = 3'd7;
   localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 4'd5;
   localparam logic [DEB_W-1:0]   DEB_COUNT_RESET = DEBOUNCE_RESET - 4'd1;
   localparam logic [BLINK_W-1:0] BLINK_RESET    = 10'd100;

   // Bit positions of the result fields in rsp_tdata.
   localparam int RSP_TOP_LSB  = 0;
   localparam int RSP_DUTY_LSB = 10;
   localparam int RSP_SPK_BIT  = 20;
   localparam int RSP_LED_BIT  = 21;
   localparam int RSP_NOTE_LSB = 22;
   localparam int RSP_OCT_BIT  = 25;

   // Item kinds carried in req_tuser.
   localparam logic KIND_PERIOD = 1'b0;
   localparam logic KIND_KEY    = 1'b1;

   // PWM period value per note C..B.
   localparam logic [PWM_W-1:0] TONE_TOP [0:NOTE_COUNT-1] =
      '{10'd764, 10'd681, 10'd607, 10'd573, 10'd510, 10'd455, 10'd405};

   // One sine period of duty values per note.
   localparam logic [PWM_W-1:0] TONE_DUTY [0:NOTE_COUNT-1][0:TABLE_SAMPLES-1] = '{
      '{10'd382, 10'd489, 10'd584, 10'd661, 10'd709, 10'd726, 10'd709, 10'd661, 10'd584,
        10'd489, 10'd382, 10'd276, 10'd180, 10'd104, 10'd55, 10'd38, 10'd55, 10'd104,
        10'd180, 10'd276},
      '{10'd341, 10'd435, 10'd521, 10'd588, 10'd632, 10'd647, 10'd632, 10'd588, 10'd521,
        10'd435, 10'd341, 10'd246, 10'd160, 10'd93, 10'd49, 10'd34, 10'd49, 10'd93,
        10'd160, 10'd246},
      '{10'd303, 10'd388, 10'd464, 10'd524, 10'd563, 10'd576, 10'd563, 10'd524, 10'd464,
        10'd388, 10'd303, 10'd219, 10'd143, 10'd82, 10'd44, 10'd30, 10'd44, 10'd82,
        10'd143, 10'd219},
      '{10'd286, 10'd366, 10'd438, 10'd495, 10'd531, 10'd544, 10'd531, 10'd495, 10'd438,
        10'd366, 10'd286, 10'd207, 10'd135, 10'd78, 10'd41, 10'd29, 10'd41, 10'd78,
        10'd135, 10'd207},
      '{10'd255, 10'd326, 10'd390, 10'd441, 10'd473, 10'd485, 10'd473, 10'd441, 10'd390,
        10'd326, 10'd255, 10'd184, 10'd120, 10'd69, 10'd37, 10'd26, 10'd37, 10'd69,
        10'd120, 10'd184},
      '{10'd227, 10'd290, 10'd348, 10'd393, 10'd422, 10'd432, 10'd422, 10'd393, 10'd348,
        10'd290, 10'd227, 10'd164, 10'd107, 10'd62, 10'd33, 10'd23, 10'd33, 10'd62,
        10'd107, 10'd164},
      '{10'd202, 10'd259, 10'd310, 10'd350, 10'd376, 10'd385, 10'd376, 10'd350, 10'd310,
        10'd259, 10'd202, 10'd146, 10'd95, 10'd55, 10'd29, 10'd20, 10'd29, 10'd55,
        10'd95, 10'd146}};

   // LED blink delay: entry 0 for no note, then C..B low octave, then C..B high octave.
   localparam logic [BLINK_W-1:0] BLINK_DELAY [0:BLINK_ENTRIES-1] =
      '{10'd977, 10'd244, 10'd194, 10'd154, 10'd122, 10'd109, 10'd86, 10'd69,
        10'd61, 10'd48, 10'd38, 10'd31, 10'd27, 10'd22, 10'd17};

   // Held note, octave and LED level as seen after the current item.
   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic              octave;
      logic              led;
   } status_type;

   // True when the note code names a playable note.
   function automatic logic note_valid(input logic [NOTE_W-1:0] note);
      return ({29'd0, note} < NOTE_COUNT);
   endfunction

   // Blink delay for a held note and octave.
   function automatic logic [BLINK_W-1:0] blink_lookup(input logic [NOTE_W-1:0] note,
                                                       input logic octave);
      logic [3:0] idx;
      idx = {1'b0, note} + 4'd1 + (octave ? 4'd7 : 4'd0);
      if (!note_valid(note)) begin
         return BLINK_DELAY[0];
      end
      return BLINK_DELAY[idx];
   endfunction

endpackage

/* hdl/dts_keys.sv */
// Key debounce, note priority and LED blink timing.
module dts_keys (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [dts_pkg::KEYS_W-1:0]  note_keys_n,
   input  logic                        octave_key_n,
   input  logic [dts_pkg::DEB_W-1:0]   debounce_ticks,
   output dts_pkg::status_type         status
);

   logic [dts_pkg::NOTE_W-1:0]  acc_note_ff, acc_note_in;
   logic                        acc_oct_ff, acc_oct_in;
   logic [dts_pkg::NOTE_W-1:0]  prev_note_ff, prev_note_in;
   logic                        prev_oct_ff, prev_oct_in;
   logic                        first_ff, first_in;
   logic [dts_pkg::DEB_W-1:0]   deb_count_ff, deb_count_in;
   logic [dts_pkg::BLINK_W-1:0] delay_ff, delay_in;
   logic [dts_pkg::BLINK_W-1:0] blink_count_ff, blink_count_in;
   logic                        phase_ff, phase_in;
   logic                        led_ff, led_in;

   logic [dts_pkg::NOTE_W-1:0]  raw_note;
   logic                        raw_oct;
   logic [dts_pkg::DEB_W:0]     deb_next;
   logic                        take_sample;
   logic                        changed;
   logic [dts_pkg::BLINK_W-1:0] blink_next;
   logic                        blink_hit;

   // Lowest pressed note wins.
   always_comb begin
      raw_note = dts_pkg::NO_NOTE;
      for (int i = dts_pkg::NOTE_COUNT - 1; i >= 0; i--) begin
         if (!note_keys_n[i]) begin
            raw_note = dts_pkg::NOTE_W'(i);
         end
      end
   end

   assign raw_oct     = ~octave_key_n;
   assign deb_next    = {1'b0, deb_count_ff} + 5'd1;
   assign take_sample = step && (deb_next >= {1'b0, debounce_ticks});

   // Debounce counter and key acceptance.
   always_comb begin
      deb_count_in = deb_count_ff;
      acc_note_in  = acc_note_ff;
      acc_oct_in   = acc_oct_ff;
      prev_note_in = prev_note_ff;
      prev_oct_in  = prev_oct_ff;
      first_in     = first_ff;
      changed      = 1'b0;
      if (step) begin
         deb_count_in = take_sample ? '0 : deb_next[dts_pkg::DEB_W-1:0];
      end
      if (take_sample) begin
         changed  = first_ff;
         first_in = 1'b0;
         if (raw_oct == prev_oct_ff) begin
            acc_oct_in = raw_oct;
            changed    = 1'b1;
         end
         if (raw_note == prev_note_ff) begin
            acc_note_in = raw_note;
            changed     = 1'b1;
         end
         prev_note_in = raw_note;
         prev_oct_in  = raw_oct;
      end
   end

   // Blink delay reload and LED toggling.
   assign delay_in   = changed ? dts_pkg::blink_lookup(acc_note_in, acc_oct_in) : delay_ff;
   assign blink_next = blink_count_ff + 10'd1;
   assign blink_hit  = blink_next >= delay_in;

   always_comb begin
      blink_count_in = blink_count_ff;
      phase_in       = phase_ff;
      led_in         = led_ff;
      if (step) begin
         blink_count_in = blink_hit ? '0 : blink_next;
         if (blink_hit) begin
            led_in   = phase_ff;
            phase_in = ~phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_note_ff    <= dts_pkg::NO_NOTE;
         acc_oct_ff     <= 1'b0;
         prev_note_ff   <= dts_pkg::NO_NOTE;
         prev_oct_ff    <= 1'b0;
         first_ff       <= 1'b1;
         deb_count_ff   <= dts_pkg::DEB_COUNT_RESET;
         delay_ff       <= dts_pkg::BLINK_RESET;
         blink_count_ff <= '0;
         phase_ff       <= 1'b0;
         led_ff         <= 1'b1;
      end else begin
         acc_note_ff    <= acc_note_in;
         acc_oct_ff     <= acc_oct_in;
         prev_note_ff   <= prev_note_in;
         prev_oct_ff    <= prev_oct_in;
         first_ff       <= first_in;
         deb_count_ff   <= deb_count_in;
         delay_ff       <= delay_in;
         blink_count_ff <= blink_count_in;
         phase_ff       <= phase_in;
         led_ff         <= led_in;
      end
   end

   // The status seen by the result is the state after this item.
   assign status.note   = acc_note_in;
   assign status.octave = acc_oct_in;
   assign status.led    = led_in;

`ifndef NO_ASSERTIONS
   // The LED only changes on a key tick.
   a_led_steady: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(led_ff))
      else $error("LED changed without a key tick");
   // The held note only changes when the keys are sampled.
   a_note_on_sample: assert property (@(posedge clock) disable iff (reset)
      !take_sample |=> $stable(acc_note_ff))
      else $error("held note changed outside a key sample");
`endif

endmodule

/* hdl/dts_tone.sv */
// Sine sample stepping and PWM table read.
module dts_tone (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  dts_pkg::status_type        status,
   output logic [dts_pkg::PWM_W-1:0]  pwm_top,
   output logic [dts_pkg::PWM_W-1:0]  pwm_duty
);

   logic [dts_pkg::IDX_W-1:0]  sample_idx_ff, sample_idx_in;
   logic [dts_pkg::IDX_W:0]    idx_sum;
   logic [dts_pkg::NOTE_W-1:0] row;

   // Without a held note the C row is read.
   assign row      = dts_pkg::note_valid(status.note) ? status.note : '0;
   assign pwm_top  = dts_pkg::TONE_TOP[row];
   assign pwm_duty = dts_pkg::TONE_DUTY[row][sample_idx_ff];

   // Step by one sample, or by two in the high octave, and wrap.
   assign idx_sum = {1'b0, sample_idx_ff} + (status.octave ? 6'd2 : 6'd1);

   always_comb begin
      sample_idx_in = sample_idx_ff;
      if (step) begin
         if (idx_sum >= 6'(dts_pkg::SAMPLES_PER_PERIOD)) begin
            sample_idx_in = '0;
         end else begin
            sample_idx_in = idx_sum[dts_pkg::IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_idx_ff <= '0;
      end else begin
         sample_idx_ff <= sample_idx_in;
      end
   end

`ifndef NO_ASSERTIONS
   // The sample index stays inside the table.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, sample_idx_ff} < 6'(dts_pkg::SAMPLES_PER_PERIOD))
      else $error("sample index out of range");
`endif

endmodule

/* hdl/diatonic_tone_sequencer_core.sv */
// Top level of the diatonic tone sequencer: item registers, config register and result packing.
// An accepted item passes through the input item register and then the result register.
// Throughput: one item per cycle; req_tready falls only while the input register holds an
// item that a stalled result register cannot take.
// Reset: synchronous, active high; clears the key, LED and sample state to their start values.
// After reset no note is held, the LED is lit and debounce_ticks reads 5.
module diatonic_tone_sequencer_core (
   input  logic                            clock,
   input  logic                            reset,
   // Input items.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dts_pkg::REQ_DATA_W-1:0]  req_tdata,   // note_keys_n[6:0], octave_key_n[7]
   input  logic                            req_tuser,   // kind[0]
   // Result items.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dts_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // pwm_top[9:0], pwm_duty[19:10],
                                                        // speaker_enable[20], led_on[21],
                                                        // current_note[24:22], high_octave[25]
   // Configuration write.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dts_pkg::DEB_W-1:0]       csr_data
);

   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_kind_ff;
   logic [dts_pkg::KEYS_W-1:0]     s1_keys_ff;
   logic                           s1_oct_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [dts_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [dts_pkg::DEB_W-1:0]      deb_ticks_ff;

   logic                           out_ready;
   logic                           advance;
   logic                           req_take;
   logic                           key_step;
   logic                           tone_step;
   dts_pkg::status_type            status;
   logic [dts_pkg::PWM_W-1:0]      tone_top;
   logic [dts_pkg::PWM_W-1:0]      tone_duty;

   // Handshake between the input register and the result register.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_take   = req_tvalid && req_tready;
   assign key_step   = advance && (s1_kind_ff == dts_pkg::KIND_KEY);
   assign tone_step  = advance && (s1_kind_ff == dts_pkg::KIND_PERIOD);

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ticks_ff <= dts_pkg::DEBOUNCE_RESET;
      end else if (csr_valid && csr_ready) begin
         deb_ticks_ff <= csr_data;
      end
   end

   // Input item register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_kind_ff <= req_tuser;
         s1_keys_ff <= req_tdata[dts_pkg::KEYS_W-1:0];
         s1_oct_ff  <= req_tdata[dts_pkg::KEYS_W];
      end
   end

   dts_keys u_keys (
      .clock          (clock),
      .reset          (reset),
      .step           (key_step),
      .note_keys_n    (s1_keys_ff),
      .octave_key_n   (s1_oct_ff),
      .debounce_ticks (deb_ticks_ff),
      .status         (status)
   );

   dts_tone u_tone (
      .clock    (clock),
      .reset    (reset),
      .step     (tone_step),
      .status   (status),
      .pwm_top  (tone_top),
      .pwm_duty (tone_duty)
   );

   // Result packing; a key tick carries zero PWM values.
   always_comb begin
      rsp_data_in = '0;
      if (s1_kind_ff == dts_pkg::KIND_PERIOD) begin
         rsp_data_in[dts_pkg::RSP_TOP_LSB +: dts_pkg::PWM_W]  = tone_top;
         rsp_data_in[dts_pkg::RSP_DUTY_LSB +: dts_pkg::PWM_W] = tone_duty;
      end
      rsp_data_in[dts_pkg::RSP_SPK_BIT]                     = dts_pkg::note_valid(status.note);
      rsp_data_in[dts_pkg::RSP_LED_BIT]                     = status.led;
      rsp_data_in[dts_pkg::RSP_NOTE_LSB +: dts_pkg::NOTE_W] = status.note;
      rsp_data_in[dts_pkg::RSP_OCT_BIT]                     = status.octave;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // Speaker enable agrees with the reported note.
   a_spk_note: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[dts_pkg::RSP_SPK_BIT] ==
                        (rsp_data_ff[dts_pkg::RSP_NOTE_LSB +: dts_pkg::NOTE_W] != dts_pkg::NO_NOTE)))
      else $error("speaker enable disagrees with note");
   // A key tick result carries zero PWM values.
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      key_step |=> (rsp_data_ff[dts_pkg::RSP_DUTY_LSB + dts_pkg::PWM_W - 1:0] == '0))
      else $error("key tick result has PWM values");
`endif

endmodule

/* tb/tone_checker.sv */
// Checker for the tone sequencer: predicts each result from the accepted items and compares it.
`timescale 1ns / 1ps

module tone_checker
   import dts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // note_keys_n[6:0], octave_key_n[7]
   input  logic                  req_tuser,   // kind[0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // pwm_top[9:0], pwm_duty[19:10],
                                              // speaker_enable[20], led_on[21],
                                              // current_note[24:22], high_octave[25]
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [DEB_W-1:0]      csr_data,
   output int                    error_count,
   output int                    in_flight
);

   // One result item as seen on rsp_tdata.
   typedef struct packed {
      logic [PWM_W-1:0]  pwm_top;
      logic [PWM_W-1:0]  pwm_duty;
      logic              speaker_enable;
      logic              led_on;
      logic [NOTE_W-1:0] current_note;
      logic              high_octave;
   } tone_result_t;

   // Predicted copy of the register and the sequencer state.
   logic [DEB_W-1:0]   debounce_ticks;
   logic [DEB_W-1:0]   debounce_count;
   logic [NOTE_W-1:0]  held_note;
   logic               held_octave;
   logic [NOTE_W-1:0]  last_raw_note;
   logic               last_raw_octave;
   logic               first_scan;
   logic [IDX_W-1:0]   sine_pos;
   logic [BLINK_W-1:0] blink_limit;
   logic [BLINK_W-1:0] blink_ticks;
   logic               blink_toggle;
   logic               led_level;

   tone_result_t expected_tones[$];
   int           result_count = 0;

   task automatic report(input string msg);
      $display("ERROR at %0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report($sformatf("result %0d %s is %0d, expected %0d", result_count, name, got, want));
      end
   endtask

   // Samples the keys: lowest pressed note wins, each value is taken once it repeats.
   task automatic scan_keys(input logic [KEYS_W-1:0] keys_n, input logic octave_n);
      logic [NOTE_W-1:0] raw_note;
      logic              raw_octave;
      logic              reload;
      raw_note   = NO_NOTE;
      raw_octave = ~octave_n;
      reload     = first_scan;
      first_scan = 1'b0;
      for (int i = NOTE_COUNT - 1; i >= 0; i--) begin
         if (!keys_n[i]) raw_note = NOTE_W'(i);
      end
      if (raw_octave == last_raw_octave) begin
         held_octave = raw_octave;
         reload      = 1'b1;
      end
      if (raw_note == last_raw_note) begin
         held_note = raw_note;
         reload    = 1'b1;
      end
      last_raw_note   = raw_note;
      last_raw_octave = raw_octave;
      // The blink rate follows the held note and octave.
      if (reload) begin
         if (held_note < NOTE_COUNT) begin
            blink_limit = BLINK_DELAY[int'(held_note) + 1 + (held_octave ? NOTE_COUNT : 0)];
         end else begin
            blink_limit = BLINK_DELAY[0];
         end
      end
   endtask

   // Advances the predicted state by one tick and gives the result it causes.
   task automatic predict_tick(input logic kind, input logic [KEYS_W-1:0] keys_n,
                               input logic octave_n, output tone_result_t res);
      logic [DEB_W:0] next_count;
      int             row;
      res = '0;
      if (kind == KIND_PERIOD) begin
         // No held note plays the C row with the speaker off.
         row          = (held_note < NOTE_COUNT) ? int'(held_note) : 0;
         res.pwm_top  = TONE_TOP[row];
         res.pwm_duty = TONE_DUTY[row][sine_pos % TABLE_SAMPLES];
         sine_pos     = sine_pos + (held_octave ? 5'd2 : 5'd1);
         if (sine_pos >= SAMPLES_PER_PERIOD) sine_pos = '0;
      end else begin
         next_count = {1'b0, debounce_count} + 1'b1;
         if (next_count >= {1'b0, debounce_ticks}) begin
            debounce_count = '0;
            scan_keys(keys_n, octave_n);
         end else begin
            debounce_count = next_count[DEB_W-1:0];
         end
         blink_ticks = blink_ticks + 1'b1;
         if (blink_ticks >= blink_limit) begin
            blink_ticks  = '0;
            led_level    = blink_toggle;
            blink_toggle = ~blink_toggle;
         end
      end
      res.speaker_enable = (held_note < NOTE_COUNT);
      res.led_on         = led_level;
      res.current_note   = held_note;
      res.high_octave    = held_octave;
   endtask

   // Watch the three channels at each rising edge.
   always @(posedge clock) begin : watch
      tone_result_t got;
      tone_result_t want;
      if (reset) begin
         debounce_ticks  = DEBOUNCE_RESET;
         debounce_count  = DEB_COUNT_RESET;
         held_note       = NO_NOTE;
         held_octave     = 1'b0;
         last_raw_note   = NO_NOTE;
         last_raw_octave = 1'b0;
         first_scan      = 1'b1;
         sine_pos        = '0;
         blink_limit     = BLINK_RESET;
         blink_ticks     = '0;
         blink_toggle    = 1'b0;
         led_level       = 1'b1;
         expected_tones.delete();
         in_flight <= 0;
      end else begin
         if (csr_valid && csr_ready) debounce_ticks = csr_data;
         // Results leave before the item of this edge is predicted.
         if (rsp_tvalid && rsp_tready) begin
            got.pwm_top        = rsp_tdata[RSP_TOP_LSB +: PWM_W];
            got.pwm_duty       = rsp_tdata[RSP_DUTY_LSB +: PWM_W];
            got.speaker_enable = rsp_tdata[RSP_SPK_BIT];
            got.led_on         = rsp_tdata[RSP_LED_BIT];
            got.current_note   = rsp_tdata[RSP_NOTE_LSB +: NOTE_W];
            got.high_octave    = rsp_tdata[RSP_OCT_BIT];
            if (expected_tones.size() == 0) begin
               report($sformatf("result %0d arrived with none expected: %h",
                                result_count, rsp_tdata));
            end else begin
               want = expected_tones.pop_front();
               compare_field("pwm_top", got.pwm_top, want.pwm_top);
               compare_field("pwm_duty", got.pwm_duty, want.pwm_duty);
               compare_field("speaker_enable", got.speaker_enable, want.speaker_enable);
               compare_field("led_on", got.led_on, want.led_on);
               compare_field("current_note", got.current_note, want.current_note);
               compare_field("high_octave", got.high_octave, want.high_octave);
            end
            result_count++;
         end
         if (req_tvalid && req_tready) begin
            predict_tick(req_tuser, req_tdata[KEYS_W-1:0], req_tdata[KEYS_W], want);
            expected_tones.push_back(want);
         end
         in_flight <= expected_tones.size();
      end
   end

endmodule

/* tb/testbench.sv */
// Top of the tone sequencer testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
   import dts_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef enum {STALL_NONE, STALL_COIN, STALL_COMB, STALL_HEAVY} stall_mode_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [DEB_W-1:0]      csr_data   = '0;

   int          error_count;
   int          in_flight;
   int          cycle_count = 0;
   int          burst_left  = 0;
   stall_mode_t stall_mode  = STALL_NONE;
   int          stall_left  = 0;
   int          stall_phase = 0;

   logic [DEB_W-1:0] debounce_plan [0:7] =
      '{4'd15, 4'd1, 4'd0, 4'd7, 4'd2, 4'd15, 4'd9, 4'd1};

   diatonic_tone_sequencer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   tone_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .error_count (error_count),
      .in_flight   (in_flight)
   );

   // Free-running clock, 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // The receiver switches between stall patterns of random length.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_t'($urandom_range(0, 3));
         stall_left <= $urandom_range(10, 150);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         STALL_NONE: begin
            rsp_tready <= 1'b1;
         end
         STALL_COIN: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         STALL_COMB: begin
            rsp_tready <= (stall_phase % 4) != 3;
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 5) == 0);
         end
      endcase
   end

   // Sends one tick; a gap of random length comes between bursts.
   task automatic push_tick(input logic kind, input logic [KEYS_W-1:0] keys_n,
                            input logic octave_n);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {octave_n, keys_n};
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // Stops sending and waits until every expected result has come.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [DEB_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Segments of held keys with mixed ticks, plus some bouncing noise.
   task automatic run_random(input int count);
      logic [KEYS_W-1:0] held_keys;
      logic              held_oct;
      int                seg_len;
      int                pick;
      int                sent;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            held_keys = ~(KEYS_W'(1) << $urandom_range(0, NOTE_COUNT - 1));
         end else if (pick <= 7) begin
            held_keys = KEYS_W'($urandom);
         end else if (pick == 8) begin
            held_keys = '1;
         end else begin
            held_keys = '0;
         end
         held_oct = 1'($urandom_range(0, 1));
         seg_len  = $urandom_range(4, 80);
         repeat (seg_len) begin
            if ($urandom_range(0, 9) == 0) begin
               push_tick(1'($urandom_range(0, 1)), KEYS_W'($urandom),
                         1'($urandom_range(0, 1)));
            end else begin
               push_tick(($urandom_range(0, 4) < 3) ? KIND_KEY : KIND_PERIOD,
                         held_keys, held_oct);
            end
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: silent C row, first key sample, ignored keys on a period tick.
      push_tick(KIND_PERIOD, 7'h7F, 1'b1);
      push_tick(KIND_KEY, 7'h7F, 1'b1);
      push_tick(KIND_PERIOD, 7'h00, 1'b0);
      push_tick(KIND_KEY, 7'h00, 1'b0);

      // Sample on every tick: take B, then the high octave, then several keys at once.
      wait_idle();
      write_debounce(4'd1);
      push_tick(KIND_KEY, 7'h3F, 1'b1);
      push_tick(KIND_KEY, 7'h3F, 1'b1);
      push_tick(KIND_PERIOD, 7'h3F, 1'b1);
      push_tick(KIND_PERIOD, 7'h3F, 1'b1);
      push_tick(KIND_PERIOD, 7'h3F, 1'b1);
      push_tick(KIND_KEY, 7'h3F, 1'b0);
      push_tick(KIND_KEY, 7'h3F, 1'b0);
      push_tick(KIND_PERIOD, 7'h3F, 1'b0);
      push_tick(KIND_PERIOD, 7'h3F, 1'b0);
      push_tick(KIND_KEY, 7'h00, 1'b0);
      push_tick(KIND_KEY, 7'h00, 1'b0);
      push_tick(KIND_PERIOD, 7'h00, 1'b0);
      push_tick(KIND_KEY, 7'h7F, 1'b1);
      push_tick(KIND_KEY, 7'h7F, 1'b1);
      push_tick(KIND_PERIOD, 7'h7F, 1'b1);

      // A zero register still samples on every key tick.
      wait_idle();
      write_debounce(4'd0);
      push_tick(KIND_KEY, 7'h5F, 1'b1);
      push_tick(KIND_KEY, 7'h5F, 1'b1);
      push_tick(KIND_PERIOD, 7'h5F, 1'b1);

      // Random phases over a range of debounce settings.
      debounce_plan[6] = DEB_W'($urandom_range(0, 15));
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         write_debounce(debounce_plan[p]);
         run_random(250);
      end

      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/dts_pkg.sv
hdl/dts_keys.sv
hdl/dts_tone.sv
hdl/diatonic_tone_sequencer_core.sv
tb/tone_checker.sv
tb/testbench.sv
